FILE: rtl/fros_pkg.sv
package fros_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned FRAC_BITS  = 10;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned ROC_THR_W  = 31;

  localparam int unsigned BASE_FREQ  = 16000;
  localparam int unsigned RATE_SCALE = 32000;
  localparam int unsigned SCALE_W    = 15;

  localparam int unsigned PROD_W = FREQ_W + SCALE_W;
  localparam int unsigned DEN_W  = COUNT_BITS + 1;
  localparam int unsigned STEP_W = $clog2(PROD_W + 1);

  localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(BASE_FREQ << FRAC_BITS);

  localparam int unsigned IN_TDATA_W  = COUNT_BITS + TICK_W;
  localparam int unsigned OUT_TDATA_W = FREQ_W + RATE_W + TICK_W;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROC_THR  = CFG_IDX_W'(1);

  localparam logic [FREQ_W-1:0]    FREQ_THR_RST = FREQ_W'(51200);
  localparam logic [ROC_THR_W-1:0] ROC_THR_RST  = ROC_THR_W'(20480);

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_rate;
    logic cap_freq;
    logic mul;
    logic cap_rate;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic seen_first;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/fros_div.sv
module fros_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [fros_pkg::PROD_W-1:0]       dividend_i,
  input  logic [fros_pkg::DEN_W-1:0]        divisor_i,
  input  logic [fros_pkg::STEP_W-1:0]       steps_i,
  output logic                              done_o,
  output logic [fros_pkg::PROD_W-1:0]       quotient_o
);

  logic [fros_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [fros_pkg::DEN_W-1:0]  rem_q, rem_d;
  logic [fros_pkg::DEN_W-1:0]  den_q, den_d;
  logic [fros_pkg::PROD_W-1:0] sh_q, sh_d;
  logic [fros_pkg::PROD_W-1:0] quo_q, quo_d;

  logic [fros_pkg::DEN_W:0]    trial;
  logic                        fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, sh_q[fros_pkg::PROD_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = steps_i;
      rem_d = '0;
      den_d = divisor_i;
      sh_d  = dividend_i;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == fros_pkg::STEP_W'(1));
      rem_d  = fits ? fros_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[fros_pkg::DEN_W-1:0];
      sh_d   = {sh_q[fros_pkg::PROD_W-2:0], 1'b0};
      quo_d  = {quo_q[fros_pkg::PROD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/fros_datapath.sv
module fros_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fros_pkg::cmd_t                      cmd_i,
  output fros_pkg::status_t                   status_o,
  input  logic [fros_pkg::IN_TDATA_W-1:0]     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fros_pkg::OUT_TDATA_W-1:0]    out_data_o,
  output logic [fros_pkg::OUT_TUSER_W-1:0]    out_user_o,
  input  logic                                cfg_we_i,
  input  logic [fros_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [fros_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam logic [fros_pkg::PROD_W-1:0] FreqDividend =
    fros_pkg::PROD_W'(fros_pkg::FREQ_MAX) << (fros_pkg::PROD_W - fros_pkg::FREQ_W);
  localparam logic [fros_pkg::PROD_W-1:0] PosLimit = fros_pkg::PROD_W'(32'h7FFF_FFFF);
  localparam logic [fros_pkg::PROD_W-1:0] NegLimit = fros_pkg::PROD_W'(32'h8000_0000);

  logic [fros_pkg::FREQ_W-1:0]     freq_thr_q;
  logic [fros_pkg::ROC_THR_W-1:0]  roc_thr_q;

  logic [fros_pkg::COUNT_BITS-1:0] last_count_q;
  logic [fros_pkg::FREQ_W-1:0]     last_freq_q;
  logic                            seen_q;

  logic [fros_pkg::COUNT_BITS-1:0] count_q;
  logic [fros_pkg::TICK_W-1:0]     tick_q;
  logic                            err_q;
  logic [fros_pkg::FREQ_W-1:0]     freq_q;
  logic [fros_pkg::PROD_W-1:0]     prod_q;
  logic [fros_pkg::DEN_W-1:0]      den_q;
  logic                            sign_q;
  logic [fros_pkg::RATE_W-1:0]     mag_q;
  logic                            neg_q;

  logic                            out_valid_q;
  logic [fros_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic [fros_pkg::OUT_TUSER_W-1:0] out_user_q;

  logic [fros_pkg::COUNT_BITS-1:0] in_count;
  logic [fros_pkg::FREQ_W-1:0]     diff;
  logic                            freq_lower;
  logic [fros_pkg::PROD_W-1:0]     div_dividend;
  logic [fros_pkg::DEN_W-1:0]      div_divisor;
  logic [fros_pkg::STEP_W-1:0]     div_steps;
  logic                            div_done;
  logic [fros_pkg::PROD_W-1:0]     quo;
  logic [fros_pkg::RATE_W-1:0]     sat_mag;
  logic [fros_pkg::RATE_W-1:0]     rate_bits;
  logic                            unstable;

  assign in_count   = in_data_i[fros_pkg::COUNT_BITS-1:0];
  assign freq_lower = (freq_q < last_freq_q);
  assign diff       = freq_lower ? (last_freq_q - freq_q) : (freq_q - last_freq_q);

  assign div_dividend = cmd_i.div_rate ? prod_q : FreqDividend;
  assign div_divisor  = cmd_i.div_rate ? den_q : fros_pkg::DEN_W'(count_q);
  assign div_steps    = cmd_i.div_rate ? fros_pkg::STEP_W'(fros_pkg::PROD_W)
                                       : fros_pkg::STEP_W'(fros_pkg::FREQ_W);

  fros_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    if (sign_q) begin
      sat_mag = (quo > NegLimit) ? NegLimit[fros_pkg::RATE_W-1:0] : quo[fros_pkg::RATE_W-1:0];
    end else begin
      sat_mag = (quo > PosLimit) ? PosLimit[fros_pkg::RATE_W-1:0] : quo[fros_pkg::RATE_W-1:0];
    end
  end

  assign rate_bits = neg_q ? (~mag_q + 1'b1) : mag_q;
  assign unstable  = err_q || (freq_q < freq_thr_q) ||
                     (mag_q > fros_pkg::RATE_W'(roc_thr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_thr_q   <= fros_pkg::FREQ_THR_RST;
      roc_thr_q    <= fros_pkg::ROC_THR_RST;
      last_count_q <= '0;
      last_freq_q  <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          fros_pkg::CFG_FREQ_THR: freq_thr_q <= cfg_data_i[fros_pkg::FREQ_W-1:0];
          fros_pkg::CFG_ROC_THR:  roc_thr_q  <= cfg_data_i[fros_pkg::ROC_THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.commit && !err_q) begin
        last_count_q <= count_q;
        last_freq_q  <= freq_q;
        seen_q       <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      count_q <= in_count;
      tick_q  <= in_data_i[fros_pkg::IN_TDATA_W-1:fros_pkg::COUNT_BITS];
      err_q   <= (in_count == '0);
      freq_q  <= fros_pkg::FREQ_MAX;
      mag_q   <= '0;
      neg_q   <= 1'b0;
    end
    if (cmd_i.cap_freq) begin
      freq_q <= quo[fros_pkg::FREQ_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= fros_pkg::PROD_W'(diff) * fros_pkg::PROD_W'(fros_pkg::RATE_SCALE);
      sign_q <= freq_lower;
      den_q  <= fros_pkg::DEN_W'(last_count_q) + fros_pkg::DEN_W'(count_q);
    end
    if (cmd_i.cap_rate) begin
      mag_q <= sat_mag;
      neg_q <= sign_q && (quo != '0);
    end
    if (cmd_i.commit) begin
      out_data_q <= {tick_q, rate_bits, freq_q};
      out_user_q <= {err_q, unstable};
    end
  end

  assign status_o.count_zero = (in_count == '0);
  assign status_o.seen_first = seen_q;
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

FILE: rtl/fros_ctrl.sv
module fros_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fros_pkg::status_t status_i,
  output fros_pkg::cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_FSTART = 7'b0000010,
    ST_FWAIT  = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_RSTART = 7'b0010000,
    ST_RWAIT  = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.count_zero ? ST_FIN : ST_FSTART;
        end
      end
      ST_FSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_FWAIT;
      end
      ST_FWAIT: begin
        if (status_i.div_done) begin
          cmd_o.cap_freq = 1'b1;
          state_d        = status_i.seen_first ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RSTART;
      end
      ST_RSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_rate  = 1'b1;
        state_d         = ST_RWAIT;
      end
      ST_RWAIT: begin
        cmd_o.div_rate = 1'b1;
        if (status_i.div_done) begin
          cmd_o.cap_rate = 1'b1;
          state_d        = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: rtl/frequency_roc_stability_check.sv
// Under-frequency and RoCoF stability check.
// Slave stream: one request per period sample (count and arrival tick).
// Master stream: one result per request, in order, with frequency, signed
// rate of change, the copied tick, and the unstable/count_error flags.
// Config channel: index 0 writes the frequency limit, index 1 the rate
// limit; other indexes are dropped. Write only while no request is in flight.
// A zero count skips both divisions, the first good sample does only the
// frequency division, and later samples do both. One shared restoring
// divider does a 24-step frequency division and a 39-step rate division,
// one quotient bit per cycle. One request is in work at a time; the next
// one is accepted the cycle after a result is written to the output register.
// If the receiver stalls, the result waits in the output register; a new
// request is still accepted and computed, then held until that register frees.
// Reset clears the previous-sample state, the output valid flag and restores
// both limits (50 Hz and 20 Hz/s).
module frequency_roc_stability_check (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] period_count, [47:16] sample_tick
  input  logic [fros_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [23:0] frequency, [55:24] rate_of_change, [87:56] result_tick
  output logic [fros_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // [0] unstable, [1] count_error
  output logic [fros_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fros_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [fros_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  fros_pkg::cmd_t    cmd;
  fros_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  fros_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fros_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .cfg_we_i    (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

FILE: tb/frequency_roc_stability_check_checker.sv
`timescale 1ns / 1ps
module frequency_roc_stability_check_checker
  import fros_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // [15:0] period_count, [47:16] sample_tick
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [23:0] frequency, [55:24] rate_of_change, [87:56] result_tick
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] unstable, [1] count_error
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            outstanding_o
);

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [RATE_W-1:0] rate_of_change;
    logic              unstable;
    logic              count_error;
    logic [TICK_W-1:0] result_tick;
  } stability_result_t;

  localparam logic [63:0] FREQ_FULL    = 64'(BASE_FREQ) << FRAC_BITS;
  localparam logic [63:0] RATE_POS_MAX = 64'h7FFF_FFFF;
  localparam logic [63:0] RATE_NEG_MAX = 64'h8000_0000;

  logic [FREQ_W-1:0]     freq_limit;
  logic [ROC_THR_W-1:0]  roc_limit;
  logic [COUNT_BITS-1:0] prev_count;
  logic [FREQ_W-1:0]     prev_freq;
  logic                  have_prev;
  stability_result_t     pending_results[$];

  assign outstanding_o = pending_results.size();

  function automatic stability_result_t compute_stability(input logic [COUNT_BITS-1:0] count,
                                                          input logic [TICK_W-1:0] tick);
    stability_result_t res;
    logic [63:0] freq;
    logic [63:0] diff;
    logic [63:0] mag;
    logic [63:0] den;
    logic        neg;
    res.result_tick = tick;
    res.count_error = 1'b0;
    mag = '0;
    neg = 1'b0;
    if (count == '0) begin
      // bad sample: saturate, flag, keep history untouched
      freq = FREQ_FULL;
      res.count_error = 1'b1;
      res.unstable = 1'b1;
    end else begin
      freq = FREQ_FULL / 64'(count);
      if (have_prev) begin
        den = 64'(prev_count) + 64'(count);
        if (den != '0) begin
          if (freq >= 64'(prev_freq)) begin
            diff = freq - 64'(prev_freq);
          end else begin
            diff = 64'(prev_freq) - freq;
            neg = 1'b1;
          end
          mag = (diff * 64'(RATE_SCALE)) / den;
          if (neg && mag > RATE_NEG_MAX) mag = RATE_NEG_MAX;
          if (!neg && mag > RATE_POS_MAX) mag = RATE_POS_MAX;
          if (mag == '0) neg = 1'b0;
        end
      end
      res.unstable = (freq < 64'(freq_limit)) || (mag > 64'(roc_limit));
      prev_count = count;
      prev_freq = freq[FREQ_W-1:0];
      have_prev = 1'b1;
    end
    res.frequency = freq[FREQ_W-1:0];
    res.rate_of_change = neg ? -mag[RATE_W-1:0] : mag[RATE_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stability_result_t want;
    stability_result_t got;
    if (!rst_ni) begin
      freq_limit = FREQ_THR_RST;
      roc_limit = ROC_THR_RST;
      prev_count = '0;
      prev_freq = '0;
      have_prev = 1'b0;
      pending_results.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_addr_i == CFG_FREQ_THR) begin
          freq_limit = cfg_data_i[FREQ_W-1:0];
        end else if (cfg_addr_i == CFG_ROC_THR) begin
          roc_limit = cfg_data_i[ROC_THR_W-1:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.frequency = m_axis_tdata[FREQ_W-1:0];
        got.rate_of_change = m_axis_tdata[FREQ_W+RATE_W-1:FREQ_W];
        got.result_tick = m_axis_tdata[FREQ_W+RATE_W+TICK_W-1:FREQ_W+RATE_W];
        got.unstable = m_axis_tuser[0];
        got.count_error = m_axis_tuser[1];
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding, result_tick %0h", got.result_tick);
          mismatch_count_o++;
        end else begin
          want = pending_results.pop_front();
          check_field("frequency", 64'(want.frequency), 64'(got.frequency));
          check_field("rate_of_change", 64'($signed(want.rate_of_change)),
                      64'($signed(got.rate_of_change)));
          check_field("unstable", 64'(want.unstable), 64'(got.unstable));
          check_field("count_error", 64'(want.count_error), 64'(got.count_error));
          check_field("result_tick", 64'(want.result_tick), 64'(got.result_tick));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(compute_stability(s_axis_tdata[COUNT_BITS-1:0],
                                                    s_axis_tdata[COUNT_BITS+TICK_W-1:COUNT_BITS]));
      end
    end
  end

endmodule

FILE: tb/frequency_roc_stability_check_tb.sv
`timescale 1ns / 1ps
module frequency_roc_stability_check_tb;
  import fros_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 100;

  logic                   clk;
  logic                   rst_n;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int          idle_cycles;
  bit          steady;
  int          walk_count;
  logic [TICK_W-1:0] tick_now;

  frequency_roc_stability_check uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data)
  );

  frequency_roc_stability_check_checker stability_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_addr_i       (cfg_addr),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) begin
      case ($urandom_range(0, 4))
        0: return COUNT_BITS'(1);
        1: return COUNT_BITS'(2);
        2: return COUNT_BITS'(3);
        3: return '1;
        default: return '1 - COUNT_BITS'(1);
      endcase
    end
    if (r < 16) return COUNT_BITS'($urandom);
    // mains-like drift around 50 Hz, occasional step
    if (r < 20) walk_count = $urandom_range(250, 400);
    else walk_count = walk_count + $urandom_range(0, 16) - 8;
    if (walk_count < 200) walk_count = 200;
    if (walk_count > 500) walk_count = 500;
    return COUNT_BITS'(walk_count);
  endfunction

  task automatic send_sample(input logic [COUNT_BITS-1:0] count, input logic [TICK_W-1:0] tick);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {tick, count};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_limits(input int phase);
    case (phase)
      0: begin
        write_reg(CFG_FREQ_THR, '0);
        write_reg(CFG_ROC_THR, '0);
      end
      1: begin
        write_reg(CFG_FREQ_THR, CFG_DATA_W'(BASE_FREQ << FRAC_BITS));
        write_reg(CFG_ROC_THR, 32'h7FFF_FFFF);
      end
      2: begin
        // upper bits beyond each register width must be dropped
        write_reg(CFG_FREQ_THR, {8'($urandom), 24'($urandom_range(48000, 52000))});
        write_reg(CFG_ROC_THR, {1'b1, 31'($urandom_range(5000, 40000))});
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
      end
      default: begin
        write_reg(CFG_FREQ_THR, $urandom_range(45000, 55000));
        write_reg(CFG_ROC_THR, $urandom_range(2000, 40000));
      end
    endcase
  endtask

  initial begin : reset_and_stimulus
    rst_n = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    idle_cycles = 0;
    steady = 1'b0;
    walk_count = 320;
    tick_now = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset limits: 50 Hz and 20 Hz/s
    send_sample(16'd0, 32'h0000_0000);
    send_sample(16'd1, 32'hFFFF_FFFF);
    send_sample(16'd2, 32'hAAAA_AAAA);
    send_sample(16'd1, 32'h5555_5555);
    send_sample(16'hFFFF, 32'h0000_0001);
    send_sample(16'hFFFF, 32'h8000_0000);
    send_sample(16'd0, 32'h7FFF_FFFF);
    send_sample(16'd320, 32'h0000_1000);
    send_sample(16'd321, 32'h0000_2000);
    send_sample(16'd320, 32'h0000_3000);
    send_sample(16'd0, 32'h0000_4000);
    send_sample(16'd319, 32'h0000_5000);
    send_sample(16'd3, 32'h0000_6000);
    send_sample(16'd2, 32'h0000_7000);
    send_sample(16'hAAAA, 32'h0000_8000);
    send_sample(16'h5555, 32'h0000_9000);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      repeat (8) @(negedge clk);
      set_limits(phase);
      steady = (phase == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 10) tick_now = $urandom;
        else tick_now = tick_now + $urandom_range(1, 40000);
        if (i == PHASE_ITEMS / 2 && phase == 4) drain();
        send_sample(pick_count(), tick_now);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : result_sink
    int run;
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      run = ($urandom_range(0, 99) < 10) ? 300 : $urandom_range(1, 12);
      m_axis_tready = 1'b1;
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

endmodule
